@@ hdl/sprc_pkg.sv @@
// ---------------------------------------------------------------------------
// Subspace projection residual package
// Shared constants, memory request/response structs and saturation helpers.
// ---------------------------------------------------------------------------
package sprc_pkg;

  localparam int MaxElectrodes = 32;
  localparam int MaxPatterns   = 8;
  localparam int SampleBits    = 24;

  localparam int EIdxW   = $clog2(MaxElectrodes);
  localparam int PIdxW   = $clog2(MaxPatterns);
  localparam int PatW    = 18;
  localparam int FitW    = 32;
  localparam int SumW    = 48;
  localparam int PatAddrW = PIdxW + EIdxW;
  localparam int FitAddrW = 2 * PIdxW;

  // Request type codes.
  localparam logic [1:0] ReqSample  = 2'd0;
  localparam logic [1:0] ReqPattern = 2'd1;
  localparam logic [1:0] ReqFitting = 2'd2;

  // Register indexes.
  localparam logic RegElectrodes = 1'b0;
  localparam logic RegPatterns   = 1'b1;

  // Result kinds.
  localparam logic KindCoef     = 1'b0;
  localparam logic KindResidual = 1'b1;

  typedef struct packed {
    logic                  pat_we;
    logic [PatAddrW-1:0]   pat_waddr;
    logic [PatW-1:0]       pat_wdata;
    logic                  pat_re;
    logic [PatAddrW-1:0]   pat_raddr;
    logic                  fit_we;
    logic [FitAddrW-1:0]   fit_waddr;
    logic [FitW-1:0]       fit_wdata;
    logic                  fit_re;
    logic [FitAddrW-1:0]   fit_raddr;
    logic                  frm_we;
    logic [EIdxW-1:0]      frm_waddr;
    logic [SampleBits-1:0] frm_wdata;
    logic                  frm_re;
    logic [EIdxW-1:0]      frm_raddr;
    logic                  sum_we;
    logic [PIdxW-1:0]      sum_waddr;
    logic [SumW-1:0]       sum_wdata;
    logic                  sum_re;
    logic [PIdxW-1:0]      sum_raddr;
    logic                  sum_clr;
  } mem_req_t;

  typedef struct packed {
    logic [PatW-1:0]       pat;
    logic [FitW-1:0]       fit;
    logic [SampleBits-1:0] frm;
    logic [SumW-1:0]       sum;
  } mem_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [61:0] x);
    logic signed [31:0] r;
    if (x > 62'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -62'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [SumW-1:0] sat48(input logic signed [57:0] x);
    logic signed [SumW-1:0] r;
    if (x > 58'sd140737488355327) r = {1'b0, {(SumW-1){1'b1}}};
    else if (x < -58'sd140737488355328) r = {1'b1, {(SumW-1){1'b0}}};
    else r = x[SumW-1:0];
    return r;
  endfunction

  function automatic logic signed [PatW-1:0] sat18(input logic signed [31:0] x);
    logic signed [PatW-1:0] r;
    if (x > 32'sd131071) r = {1'b0, {(PatW-1){1'b1}}};
    else if (x < -32'sd131072) r = {1'b1, {(PatW-1){1'b0}}};
    else r = x[PatW-1:0];
    return r;
  endfunction

  function automatic logic signed [SampleBits-1:0] sat_sample(input logic signed [31:0] x);
    logic signed [SampleBits-1:0] r;
    logic signed [32:0] hi;
    logic signed [32:0] lo;
    hi = 33'sd1 <<< (SampleBits - 1);
    lo = -hi;
    hi = hi - 33'sd1;
    if (33'(x) > hi) r = {1'b0, {(SampleBits-1){1'b1}}};
    else if (33'(x) < lo) r = {1'b1, {(SampleBits-1){1'b0}}};
    else r = x[SampleBits-1:0];
    return r;
  endfunction

endpackage

@@ hdl/subspace_projection_residual_core.sv @@
// ---------------------------------------------------------------------------
// Subspace projection residual core
// Per-frame least-squares fit of a sample frame onto stored pattern rows.
// ---------------------------------------------------------------------------
// The input stream carries three kinds of item, selected by tuser: frame
// samples, pattern table entries and fitting matrix entries. Table loads
// are written in the cycle they are accepted. Each sample is stored in the
// frame memory and folded into the projection sums b = P*v, one pattern per
// step of the shared multiplier. After the last sample of a frame the block
// emits pattern_count coefficient items and then electrode_count residual
// items on the output stream, the final residual flagged by tlast. All
// results are worked out with the single 32x25 multiplier.
// The input stream is held off (tready low) while a sample or a frame is
// being worked on. Results pass through an output register; when the
// receiver stalls, the sequencer waits with the next result until that
// register is free, and a new item can enter while the last result waits.
// Reset clears the sequencer, the sample position, the projection sums and
// the registers (electrode_count 32, pattern_count 0); table contents are
// undefined until loaded. Registers are written through the APB port; the
// user must write them only while the block is idle, which the block
// itself does not enforce.
// ---------------------------------------------------------------------------
module subspace_projection_residual_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] row_index, [7:3] column_index, [39:8] value_in
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser_i,
  // Result items.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [4:0] result_index, [36:5] result_value, [39:37] zero
  output logic [39:0] m_axis_tdata_o,
  // [0] result_kind, [1] config_error
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_S_RD   = 4'd1;
  localparam logic [3:0] ST_S_MUL  = 4'd2;
  localparam logic [3:0] ST_S_ACC  = 4'd3;
  localparam logic [3:0] ST_CHK    = 4'd4;
  localparam logic [3:0] ST_C_RD   = 4'd5;
  localparam logic [3:0] ST_C_MUL1 = 4'd6;
  localparam logic [3:0] ST_C_MUL2 = 4'd7;
  localparam logic [3:0] ST_C_ACC  = 4'd8;
  localparam logic [3:0] ST_C_EMIT = 4'd9;
  localparam logic [3:0] ST_R_RD0  = 4'd10;
  localparam logic [3:0] ST_R_RD   = 4'd11;
  localparam logic [3:0] ST_R_MUL  = 4'd12;
  localparam logic [3:0] ST_R_ACC  = 4'd13;
  localparam logic [3:0] ST_R_EMIT = 4'd14;

  localparam int PW = sprc_pkg::PIdxW;
  localparam int EW = sprc_pkg::EIdxW;

  // Configuration registers.
  logic [5:0] ec_q;
  logic [3:0] pc_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ec_q <= 6'd32;
      pc_q <= 4'd0;
    end else if (cfg_we) begin
      if (paddr[2] == sprc_pkg::RegElectrodes) ec_q <= pwdata[5:0];
      else pc_q <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == sprc_pkg::RegPatterns) ? {28'd0, pc_q} : {26'd0, ec_q};

  // Effective counts: zero electrodes act as one, larger counts are clamped.
  logic [5:0] ne_eff;
  logic [3:0] np_eff;

  always_comb begin
    if (ec_q == 6'd0) ne_eff = 6'd1;
    else if (ec_q > 6'(sprc_pkg::MaxElectrodes)) ne_eff = 6'(sprc_pkg::MaxElectrodes);
    else ne_eff = ec_q;
    np_eff = (pc_q > 4'(sprc_pkg::MaxPatterns)) ? 4'(sprc_pkg::MaxPatterns) : pc_q;
  end

  // Sequencer state.
  logic [3:0]  state_q, state_d;
  logic [5:0]  pos_q, pos_d;
  logic [PW-1:0] p_q, p_d;
  logic [PW-1:0] q_q, q_d;
  logic [EW-1:0] e_q, e_d;
  logic        err_q, err_d;
  logic signed [sprc_pkg::SampleBits-1:0] val_q;
  logic signed [59:0] hi_q, hi_d;
  logic signed [59:0] lo_q, lo_d;
  logic signed [31:0] cf_q [sprc_pkg::MaxPatterns];
  logic        cf_we;

  // Output register.
  logic        out_vld_q;
  logic        out_kind_q, out_last_q, out_err_q;
  logic [4:0]  out_idx_q;
  logic [31:0] out_val_q;
  logic        out_free, out_load;
  logic        ld_kind, ld_last;
  logic [4:0]  ld_idx;
  logic signed [31:0] ld_val;

  sprc_pkg::mem_req_t req;
  sprc_pkg::mem_rsp_t rsp;

  logic signed [31:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [56:0] prod;

  sprc_store u_store (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  sprc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  logic in_acc;
  logic signed [31:0] in_val;
  logic [2:0] in_row;
  logic [4:0] in_col;
  logic [1:0] in_req;
  logic       p_last;
  logic [5:0] pos_inc;
  logic signed [59:0] lo_rnd, acc_rnd;
  logic signed [61:0] cf_wide, res_wide;
  logic signed [31:0] cf_val, res_val;
  logic signed [sprc_pkg::SampleBits-1:0] frm_v;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign in_row  = s_axis_tdata_i[2:0];
  assign in_col  = s_axis_tdata_i[7:3];
  assign in_val  = s_axis_tdata_i[39:8];
  assign in_req  = s_axis_tuser_i;
  assign out_free = ~out_vld_q | m_axis_tready_i;
  assign p_last  = ({1'b0, p_q} == np_eff - 4'd1);
  assign pos_inc = pos_q + 6'd1;
  assign frm_v   = rsp.frm;

  // Coefficient rounding: 2*hi + floor((lo + 2^22) / 2^23).
  assign lo_rnd  = lo_q + 60'sd4194304;
  assign cf_wide = {hi_q[59], hi_q, 1'b0} + 62'(lo_rnd >>> 23);
  assign cf_val  = err_q ? 32'sd0 : sprc_pkg::sat32(cf_wide);
  // Residual: sample minus the rounded reconstruction.
  assign acc_rnd  = hi_q + 60'sd4194304;
  assign res_wide = 62'(frm_v) - 62'(acc_rnd >>> 23);
  assign res_val  = err_q ? 32'(frm_v) : sprc_pkg::sat32(res_wide);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_S_MUL: begin
        mul_a = 32'(val_q);
        mul_b = 25'(signed'(rsp.pat));
      end
      ST_C_MUL1: begin
        mul_a = signed'(rsp.fit);
        mul_b = 25'(signed'(rsp.sum[47:24]));
      end
      ST_C_MUL2: begin
        mul_a = signed'(rsp.fit);
        mul_b = {1'b0, rsp.sum[23:0]};
      end
      ST_R_MUL: begin
        mul_a = cf_q[p_q];
        mul_b = 25'(signed'(rsp.pat));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    p_d     = p_q;
    q_d     = q_q;
    e_d     = e_q;
    err_d   = err_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    cf_we   = 1'b0;
    out_load = 1'b0;
    ld_kind = sprc_pkg::KindCoef;
    ld_last = 1'b0;
    ld_idx  = '0;
    ld_val  = '0;
    req     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req)
            sprc_pkg::ReqSample: begin
              req.frm_we    = 1'b1;
              req.frm_waddr = pos_q[EW-1:0];
              req.frm_wdata = sprc_pkg::sat_sample(in_val);
              p_d = '0;
              state_d = (np_eff == 4'd0) ? ST_CHK : ST_S_RD;
            end
            sprc_pkg::ReqPattern: begin
              req.pat_we    = 1'b1;
              req.pat_waddr = {in_row, in_col};
              req.pat_wdata = sprc_pkg::sat18(in_val);
            end
            sprc_pkg::ReqFitting: begin
              req.fit_we    = (in_col[4:3] == 2'b00);
              req.fit_waddr = {in_row, in_col[2:0]};
              req.fit_wdata = in_val;
            end
            default: ;
          endcase
        end
      end
      ST_S_RD: begin
        req.pat_re    = 1'b1;
        req.pat_raddr = {p_q, pos_q[EW-1:0]};
        req.sum_re    = 1'b1;
        req.sum_raddr = p_q;
        state_d = ST_S_MUL;
      end
      ST_S_MUL: state_d = ST_S_ACC;
      ST_S_ACC: begin
        req.sum_we    = 1'b1;
        req.sum_waddr = p_q;
        req.sum_wdata = sprc_pkg::sat48(58'(signed'(rsp.sum)) + 58'(prod));
        p_d = p_q + 1'b1;
        state_d = p_last ? ST_CHK : ST_S_RD;
      end
      ST_CHK: begin
        if (pos_inc >= ne_eff) begin
          err_d = ({2'b00, np_eff} > ne_eff);
          p_d = '0;
          q_d = '0;
          e_d = '0;
          hi_d = '0;
          lo_d = '0;
          if (np_eff == 4'd0) state_d = ST_R_RD0;
          else if (err_d) state_d = ST_C_EMIT;
          else state_d = ST_C_RD;
        end else begin
          pos_d = pos_inc;
          state_d = ST_IDLE;
        end
      end
      ST_C_RD: begin
        req.fit_re    = 1'b1;
        req.fit_raddr = {p_q, q_q};
        req.sum_re    = 1'b1;
        req.sum_raddr = q_q;
        state_d = ST_C_MUL1;
      end
      ST_C_MUL1: state_d = ST_C_MUL2;
      ST_C_MUL2: begin
        hi_d = hi_q + 60'(prod);
        state_d = ST_C_ACC;
      end
      ST_C_ACC: begin
        lo_d = lo_q + 60'(prod);
        q_d = q_q + 1'b1;
        state_d = ({1'b0, q_q} == np_eff - 4'd1) ? ST_C_EMIT : ST_C_RD;
      end
      ST_C_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = sprc_pkg::KindCoef;
          ld_idx   = 5'(p_q);
          ld_val   = cf_val;
          cf_we    = 1'b1;
          hi_d = '0;
          lo_d = '0;
          q_d  = '0;
          p_d  = p_q + 1'b1;
          if (p_last) state_d = ST_R_RD0;
          else state_d = err_q ? ST_C_EMIT : ST_C_RD;
        end
      end
      ST_R_RD0: begin
        req.frm_re    = 1'b1;
        req.frm_raddr = e_q;
        hi_d = '0;
        p_d  = '0;
        state_d = (err_q || np_eff == 4'd0) ? ST_R_EMIT : ST_R_RD;
      end
      ST_R_RD: begin
        req.pat_re    = 1'b1;
        req.pat_raddr = {p_q, e_q};
        state_d = ST_R_MUL;
      end
      ST_R_MUL: state_d = ST_R_ACC;
      ST_R_ACC: begin
        hi_d = hi_q + 60'(prod);
        p_d  = p_q + 1'b1;
        state_d = p_last ? ST_R_EMIT : ST_R_RD;
      end
      ST_R_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = sprc_pkg::KindResidual;
          ld_idx   = e_q;
          ld_val   = res_val;
          ld_last  = ({1'b0, e_q} == ne_eff - 6'd1);
          if (ld_last) begin
            req.sum_clr = 1'b1;
            pos_d   = '0;
            state_d = ST_IDLE;
          end else begin
            e_d = e_q + 1'b1;
            state_d = ST_R_RD0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      p_q       <= '0;
      q_q       <= '0;
      e_q       <= '0;
      err_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      p_q       <= p_d;
      q_q       <= q_d;
      e_q       <= e_d;
      err_q     <= err_d;
      out_vld_q <= out_load | (out_vld_q & ~m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (in_acc && in_req == sprc_pkg::ReqSample) val_q <= sprc_pkg::sat_sample(in_val);
    if (cf_we) cf_q[p_q] <= cf_val;
    if (out_load) begin
      out_kind_q <= ld_kind;
      out_idx_q  <= ld_idx;
      out_val_q  <= ld_val;
      out_last_q <= ld_last;
      out_err_q  <= err_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'd0, out_val_q, out_idx_q};
  assign m_axis_tuser_o  = {out_err_q, out_kind_q};
  assign m_axis_tlast_o  = out_last_q;

  // The frame always ends on a residual.
  a_last_is_residual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tuser_o[0] == sprc_pkg::KindResidual))
    else $error("last result is not a residual");

  // Coefficient indexes stay within the pattern rows.
  a_coef_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0] == sprc_pkg::KindCoef) |->
      (m_axis_tdata_o[4:PW] == '0))
    else $error("coefficient index out of range");

  // The sample loop only runs with at least one pattern enabled.
  a_sample_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S_RD) |-> (np_eff != 4'd0))
    else $error("sample step with no patterns");

  // A result is only loaded when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten");

endmodule

@@ hdl/sprc_mul.sv @@
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed 32 x 25 multiply with a registered product.
// ---------------------------------------------------------------------------
module sprc_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [24:0] b_i,
  output logic signed [56:0] prod_o
);

  logic signed [56:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= 57'(a_i) * 57'(b_i);
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/sprc_store.sv @@
// ---------------------------------------------------------------------------
// Table storage
// Pattern, fitting, frame and projection sum memories with registered reads.
// ---------------------------------------------------------------------------
module sprc_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sprc_pkg::mem_req_t req_i,
  output sprc_pkg::mem_rsp_t rsp_o
);

  logic [sprc_pkg::PatW-1:0]       pat_mem [2**sprc_pkg::PatAddrW];
  logic [sprc_pkg::FitW-1:0]       fit_mem [2**sprc_pkg::FitAddrW];
  logic [sprc_pkg::SampleBits-1:0] frm_mem [sprc_pkg::MaxElectrodes];
  logic [sprc_pkg::SumW-1:0]       sum_mem [sprc_pkg::MaxPatterns];

  logic [sprc_pkg::PatW-1:0]       pat_rd_q;
  logic [sprc_pkg::FitW-1:0]       fit_rd_q;
  logic [sprc_pkg::SampleBits-1:0] frm_rd_q;
  logic [sprc_pkg::SumW-1:0]       sum_rd_q;
  logic                            sum_vld_rd_q;
  logic [sprc_pkg::MaxPatterns-1:0] sum_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.pat_we) pat_mem[req_i.pat_waddr] <= req_i.pat_wdata;
    if (req_i.pat_re) pat_rd_q <= pat_mem[req_i.pat_raddr];
    if (req_i.fit_we) fit_mem[req_i.fit_waddr] <= req_i.fit_wdata;
    if (req_i.fit_re) fit_rd_q <= fit_mem[req_i.fit_raddr];
    if (req_i.frm_we) frm_mem[req_i.frm_waddr] <= req_i.frm_wdata;
    if (req_i.frm_re) frm_rd_q <= frm_mem[req_i.frm_raddr];
    if (req_i.sum_we) sum_mem[req_i.sum_waddr] <= req_i.sum_wdata;
    if (req_i.sum_re) sum_rd_q <= sum_mem[req_i.sum_raddr];
  end

  // A sum that was not written since the last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q    <= '0;
      sum_vld_rd_q <= 1'b0;
    end else begin
      if (req_i.sum_re) sum_vld_rd_q <= sum_vld_q[req_i.sum_raddr];
      if (req_i.sum_clr) sum_vld_q <= '0;
      else if (req_i.sum_we) sum_vld_q[req_i.sum_waddr] <= 1'b1;
    end
  end

  assign rsp_o.pat = pat_rd_q;
  assign rsp_o.fit = fit_rd_q;
  assign rsp_o.frm = frm_rd_q;
  assign rsp_o.sum = sum_vld_rd_q ? sum_rd_q : '0;

endmodule

@@ tb/subspace_projection_residual_core_tb.sv @@
// ---------------------------------------------------------------------------
// Subspace projection residual core testbench
// Loads the pattern and fitting tables, streams sample frames under several
// register settings and stall patterns, and checks every coefficient and
// residual item against a cycle-free predictor of the fixed-point fit.
// ---------------------------------------------------------------------------
module subspace_projection_residual_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ReqIgnored = 2'd3;
  localparam int         CycleLimit = 2000000;
  localparam int         SettleCycles = 100;
  localparam int         NumPhases = 9;
  localparam int         RandPerPhase = 24;
  localparam int         FullCols = 12;  // columns filled in every pattern row
  localparam int         FullRows = 2;   // rows filled across all columns

  typedef struct {
    logic [1:0]  req;
    logic [2:0]  row;
    logic [4:0]  col;
    logic [31:0] value;
    bit          drain;  // hold this item until all results have come back
  } in_item_t;

  typedef struct {
    logic        kind;
    logic [4:0]  index;
    logic [31:0] value;
    logic        last;
    logic        err;
  } fit_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  subspace_projection_residual_core DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tuser_o,
    .m_axis_tlast_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Queues between the stimulus, the driver, the predictor and the monitor.
  in_item_t    pending_items_q[$];
  fit_result_t fit_results_q[$];
  in_item_t    cur_item;
  bit          took_item;
  int          idle_mode;
  int          errors;
  int          cycles;
  int          items_sent;
  int          frames_done;
  int          results_seen;

  // Predictor state: raw registers and the table contents as the block holds them.
  int unsigned electrodes_reg;
  int unsigned patterns_reg;
  longint      pat_tab[sprc_pkg::MaxPatterns][sprc_pkg::MaxElectrodes];
  longint      fit_tab[sprc_pkg::MaxPatterns][sprc_pkg::MaxPatterns];
  longint      frame_tab[sprc_pkg::MaxElectrodes];
  longint      proj_sum[sprc_pkg::MaxPatterns];
  int unsigned sample_pos;

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Apply one accepted item to the predictor and queue the results it causes.
  task automatic predict_fit(input in_item_t it);
    int unsigned ne;
    int unsigned np;
    longint      v;
    longint      cf[sprc_pkg::MaxPatterns];
    longint      recon;
    logic signed [95:0] acc;
    logic signed [95:0] qa;
    logic signed [95:0] qb;
    bit          err;
    fit_result_t r;
    v = longint'($signed(it.value));
    if (it.req == sprc_pkg::ReqPattern) begin
      pat_tab[it.row][it.col] = clip(v, -131072, 131071);
      return;
    end
    if (it.req == sprc_pkg::ReqFitting) begin
      // Columns at or above the pattern limit are dropped by the block.
      if (it.col < sprc_pkg::MaxPatterns) fit_tab[it.row][it.col] = v;
      return;
    end
    if (it.req != sprc_pkg::ReqSample) return;
    ne = (electrodes_reg == 0) ? 1
       : ((electrodes_reg > sprc_pkg::MaxElectrodes) ? sprc_pkg::MaxElectrodes
                                                     : electrodes_reg);
    np = (patterns_reg > sprc_pkg::MaxPatterns) ? sprc_pkg::MaxPatterns : patterns_reg;
    v = clip(v, -(64'sd1 <<< (sprc_pkg::SampleBits - 1)),
             (64'sd1 <<< (sprc_pkg::SampleBits - 1)) - 1);
    if (sample_pos < sprc_pkg::MaxElectrodes) begin
      frame_tab[sample_pos] = v;
      for (int p = 0; p < np; p++)
        proj_sum[p] = clip(proj_sum[p] + pat_tab[p][sample_pos] * v,
                           -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    end
    sample_pos = (sample_pos + 1) & 63;
    if (sample_pos < ne) return;
    // Frame complete: coefficients first, then one residual per electrode.
    err = np > ne;
    for (int p = 0; p < np; p++) begin
      acc = 0;
      if (!err)
        for (int q = 0; q < np; q++) begin
          qa = fit_tab[p][q];
          qb = proj_sum[q];
          acc += qa * qb;
        end
      acc = (acc + 96'sd4194304) >>> 23;
      if (err) cf[p] = 0;
      else if (acc > 96'sd2147483647) cf[p] = 64'sd2147483647;
      else if (acc < -96'sd2147483648) cf[p] = -64'sd2147483648;
      else cf[p] = longint'(acc);
      r = '{kind: sprc_pkg::KindCoef, index: p[4:0], value: cf[p][31:0], last: 1'b0,
            err: err};
      fit_results_q.push_back(r);
    end
    for (int e = 0; e < ne; e++) begin
      recon = 0;
      if (!err)
        for (int p = 0; p < np; p++) recon += pat_tab[p][e] * cf[p];
      recon = err ? frame_tab[e]
                  : clip(frame_tab[e] - ((recon + 4194304) >>> 23),
                         -64'sd2147483648, 64'sd2147483647);
      r = '{kind: sprc_pkg::KindResidual, index: e[4:0], value: recon[31:0],
            last: (e + 1 == ne), err: err};
      fit_results_q.push_back(r);
    end
    sample_pos = 0;
    foreach (proj_sum[p]) proj_sum[p] = 0;
    frames_done++;
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle counter doubles as the watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               fit_results_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender side: the item is taken at a rising edge with tvalid and tready high,
  // and the predictor is updated right there.
  always @(posedge clk_i) begin
    took_item <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      predict_fit(cur_item);
      items_sent++;
    end
  end

  // Driver: a new item is presented at the falling edge once the last one has
  // been taken. Random gaps follow the current idle mode. An item marked for
  // draining waits until every outstanding result has arrived.
  always @(negedge clk_i) begin
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 15 : ((idle_mode == 1) ? 55 : 0);
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || took_item) begin
      if (pending_items_q.size() > 0 && $urandom_range(0, 99) >= gap_pct &&
          !(pending_items_q[0].drain && fit_results_q.size() > 0)) begin
        cur_item = pending_items_q.pop_front();
        s_axis_tdata_i  <= {cur_item.value, cur_item.col, cur_item.row};
        s_axis_tuser_i  <= cur_item.req;
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver stalls, also changed at the falling edge.
  always @(negedge clk_i) begin
    int stall_pct;
    stall_pct = (idle_mode == 0) ? 55 : ((idle_mode == 1) ? 15 : 0);
    m_axis_tready_i <= $urandom_range(0, 99) >= stall_pct;
  end

  // Monitor: each accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    fit_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (fit_results_q.size() == 0) begin
        $error("Unexpected result item: index %0d value %0d", m_axis_tdata_o[4:0],
               $signed(m_axis_tdata_o[36:5]));
        errors++;
      end else begin
        want = fit_results_q.pop_front();
        if (m_axis_tuser_o[0] !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, m_axis_tuser_o[0]);
          errors++;
        end
        if (m_axis_tdata_o[4:0] !== want.index) begin
          $error("result_index: expected %0d, got %0d", want.index, m_axis_tdata_o[4:0]);
          errors++;
        end
        if (m_axis_tdata_o[36:5] !== want.value) begin
          $error("result_value: expected %0d, got %0d", $signed(want.value),
                 $signed(m_axis_tdata_o[36:5]));
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, m_axis_tlast_o);
          errors++;
        end
        if (m_axis_tuser_o[1] !== want.err) begin
          $error("config_error: expected %0d, got %0d", want.err, m_axis_tuser_o[1]);
          errors++;
        end
      end
    end
  end

  // Register write followed by a read-back, each with a setup and an access phase.
  task automatic reg_write(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == sprc_pkg::RegElectrodes) electrodes_reg = value & 63;
    else patterns_reg = value & 15;
    want = (idx == sprc_pkg::RegElectrodes) ? (value & 63) : (value & 15);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) begin
      $error("register %0d read-back: expected %0d, got %0d", idx, want, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic in_item_t mk(input logic [1:0] req, input logic [2:0] row,
                                  input logic [4:0] col, input logic [31:0] value);
    return '{req: req, row: row, col: col, value: value, drain: 1'b0};
  endfunction

  // Sample values: mostly moderate, sometimes full range so that they saturate.
  function automatic logic [31:0] rand_sample();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 32'($urandom_range(0, 200000)) - 32'd100000;
    if (k < 9) return $urandom;
    return (k[0]) ? 32'h7FFFFFFF : 32'h80000000;
  endfunction

  // Pattern entries: mostly within plus or minus one in Q2.15, seldom beyond.
  function automatic logic [31:0] rand_pattern();
    if ($urandom_range(0, 19) == 0) return $urandom;
    return 32'($urandom_range(0, 65536)) - 32'd32768;
  endfunction

  // Fitting entries: mostly within plus or minus two in Q15.16.
  function automatic logic [31:0] rand_fitting();
    if ($urandom_range(0, 14) == 0) return $urandom;
    return 32'($urandom_range(0, 262144)) - 32'd131072;
  endfunction

  function automatic in_item_t rand_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 78) return mk(sprc_pkg::ReqSample, 3'($urandom), 5'($urandom), rand_sample());
    if (k < 88) return mk(sprc_pkg::ReqPattern, 3'($urandom), 5'($urandom), rand_pattern());
    if (k < 96) begin
      // Mostly in-range fitting columns; now and then one that is dropped.
      if ($urandom_range(0, 3) == 0)
        return mk(sprc_pkg::ReqFitting, 3'($urandom), 5'($urandom), rand_fitting());
      return mk(sprc_pkg::ReqFitting, 3'($urandom), 5'($urandom_range(0, 7)),
                rand_fitting());
    end
    return mk(ReqIgnored, 3'($urandom), 5'($urandom), $urandom);
  endfunction

  // Register settings per phase: electrode_count, pattern_count. Out-of-range
  // values and the case with more patterns than electrodes are included. Wide
  // frames use at most two patterns, and a one-electrode phase follows them so
  // that a frame left open never reaches a pattern entry beyond the filled part.
  int phase_electrodes[NumPhases] = '{32, 32, 63, 0, 3, 12, 1, 5, 8};
  int phase_patterns[NumPhases]   = '{0, 2, 1, 2, 15, 8, 1, 3, 8};

  initial begin
    in_item_t it;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = sprc_pkg::ReqSample;
    m_axis_tready_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    took_item = 1'b0;
    idle_mode = 0;
    errors = 0; cycles = 0; items_sent = 0; frames_done = 0; results_seen = 0;
    electrodes_reg = 32; patterns_reg = 0; sample_pos = 0;
    foreach (proj_sum[p]) proj_sum[p] = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_mode = (ph * 3) / NumPhases;
      reg_write(sprc_pkg::RegElectrodes, phase_electrodes[ph]);
      reg_write(sprc_pkg::RegPatterns, phase_patterns[ph]);
      if (ph == 0) begin
        // Fill every pattern entry that the settings above can reach and the
        // whole fitting table, so no later read touches an unwritten entry.
        for (int p = 0; p < sprc_pkg::MaxPatterns; p++)
          for (int e = 0; e < FullCols; e++)
            pending_items_q.push_back(mk(sprc_pkg::ReqPattern, 3'(p), 5'(e),
                                         rand_pattern()));
        for (int p = 0; p < FullRows; p++)
          for (int e = FullCols; e < sprc_pkg::MaxElectrodes; e++)
            pending_items_q.push_back(mk(sprc_pkg::ReqPattern, 3'(p), 5'(e),
                                         rand_pattern()));
        for (int p = 0; p < sprc_pkg::MaxPatterns; p++)
          for (int q = 0; q < sprc_pkg::MaxPatterns; q++)
            pending_items_q.push_back(mk(sprc_pkg::ReqFitting, 3'(p), 5'(q),
                                         rand_fitting()));
        // Directed: saturating pattern loads, extreme fitting entries, a dropped
        // fitting load, an ignored request type and a frame of extreme samples.
        pending_items_q.push_back(mk(sprc_pkg::ReqPattern, 3'd7, 5'd31, 32'h7FFFFFFF));
        pending_items_q.push_back(mk(sprc_pkg::ReqPattern, 3'd0, 5'd0, 32'h80000000));
        pending_items_q.push_back(mk(sprc_pkg::ReqPattern, 3'd1, 5'd1, 32'h0001FFFF));
        pending_items_q.push_back(mk(sprc_pkg::ReqFitting, 3'd0, 5'd0, 32'h7FFFFFFF));
        pending_items_q.push_back(mk(sprc_pkg::ReqFitting, 3'd7, 5'd7, 32'h80000000));
        pending_items_q.push_back(mk(sprc_pkg::ReqFitting, 3'd2, 5'd31, 32'h12345678));
        pending_items_q.push_back(mk(ReqIgnored, 3'd7, 5'd31, 32'hFFFFFFFF));
        for (int e = 0; e < sprc_pkg::MaxElectrodes; e++) begin
          case (e % 6)
            0: it = mk(sprc_pkg::ReqSample, 3'd7, 5'd31, 32'h7FFFFFFF);
            1: it = mk(sprc_pkg::ReqSample, 3'd0, 5'd0, 32'h80000000);
            2: it = mk(sprc_pkg::ReqSample, 3'd5, 5'd10, 32'h007FFFFF);
            3: it = mk(sprc_pkg::ReqSample, 3'd2, 5'd21, 32'hFF800000);
            4: it = mk(sprc_pkg::ReqSample, 3'd3, 5'd3, 32'h00000000);
            default: it = mk(sprc_pkg::ReqSample, 3'($urandom), 5'($urandom),
                             rand_sample());
          endcase
          pending_items_q.push_back(it);
        end
      end
      // Random part; phases may end mid-frame, so the next register write lands
      // in the middle of a frame as well.
      for (int i = 0; i < RandPerPhase; i++) begin
        it = rand_item();
        if (ph == 4 && i == 20) it.drain = 1'b1;
        pending_items_q.push_back(it);
      end
      do @(posedge clk_i);
      while (pending_items_q.size() > 0 || s_axis_tvalid_i || fit_results_q.size() > 0);
      // A trailing sample may still be in work without any result due.
      repeat (SettleCycles) @(posedge clk_i);
    end

    $display("Covered %0d input items, %0d frames and %0d result items", items_sent,
             frames_done, results_seen);
    $display("over %0d register settings and three stall patterns.", NumPhases);
    if (errors == 0 && fit_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (fit_results_q.size() > 0)
        $error("%0d expected results never arrived", fit_results_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
